// ===== src/sitda_pkg.sv =====
// Shared types and constants for the signed integer to decimal text core.
package sitda_pkg;

  typedef logic [6:0] char_t;

  localparam char_t CHAR_MINUS = 7'd45;
  localparam char_t CHAR_ZERO  = 7'd48;

  localparam int unsigned BITS_PER_STAGE = 8;
  localparam int unsigned DIGIT_W        = 4;

endpackage

// ===== src/signed_int_to_decimal_ascii_core.sv =====
// Signed two's complement integer to decimal ASCII text, one character per result request.
//
// Each input request is a VALUE_WIDTH-bit signed integer. The core sends back its decimal
// text, most significant character first: a '-' for negative values, then the digits with no
// leading zeros. Zero gives a single '0'. The most negative value is handled through its
// unsigned magnitude, so it gives "-2147483648" at 32 bits. out_last_char marks the final
// character of each value. Conversion runs in a double-dabble pipeline. There is one input
// register stage and then one stage for every 8 magnitude bits, which is 4 stages at 32 bits.
// Behind the pipeline a serializer emits one character per cycle into the output register
// while the output is not stalled. It takes the next value as it emits the last character
// of the previous one, so values follow each other without a gap. A value has 1 to 11
// characters at 32 bits: its digits, plus one '-' for a negative value. Back-pressure on
// the output stalls the input through the pipeline. Nothing is lost or repeated.
module signed_int_to_decimal_ascii_core #(
  parameter int VALUE_WIDTH = 32
) (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  logic [VALUE_WIDTH-1:0] in_value,
  output logic                   out_valid,
  input  logic                   out_stall,
  output sitda_pkg::char_t       out_char_code,
  output logic                   out_last_char
);

  import sitda_pkg::*;

  localparam int BPS  = BITS_PER_STAGE;
  localparam int NSTG = (VALUE_WIDTH + BPS - 1) / BPS;
  localparam int PADW = NSTG * BPS;
  // Upper bound on decimal digits of 2^VALUE_WIDTH - 1 (1233/4096 ~ log10 2)
  localparam int NDIG = ((VALUE_WIDTH * 1233) >> 12) + 1;
  localparam int IDXW = $clog2(NDIG);

  typedef logic [NDIG-1:0][DIGIT_W-1:0] bcd_t;

  // Eight shift-and-correct steps, MSB of the chunk first
  function automatic bcd_t dabble_chunk(input bcd_t bcd_in, input logic [BPS-1:0] bits);
    bcd_t acc;
    acc = bcd_in;
    for (int j = BPS - 1; j >= 0; j--) begin
      for (int d = 0; d < NDIG; d++) begin
        if (acc[d] >= DIGIT_W'(5)) begin
          acc[d] = acc[d] + DIGIT_W'(3);
        end
      end
      acc = bcd_t'({acc, bits[j]});
    end
    return acc;
  endfunction

  // Pipeline state
  logic            vld_r [0:NSTG];
  logic            neg_r [0:NSTG];
  logic [PADW-1:0] bin_r [0:NSTG-1];
  bcd_t            bcd_r [1:NSTG];
  logic [NSTG+1:0] rdy;

  // Serializer and output register
  logic             ser_vld_r;
  logic             ser_neg_r;
  bcd_t             ser_bcd_r;
  logic [IDXW-1:0]  ser_idx_r;
  logic             out_valid_r;
  char_t            out_char_r;
  logic             out_last_r;

  logic                   in_neg;
  logic [VALUE_WIDTH-1:0] in_mag;
  logic [IDXW-1:0]        top_idx;
  logic                   out_free;
  logic                   emit;
  logic                   last_nxt;
  char_t                  char_nxt;
  logic                   ser_done;
  logic                   ser_load;

  assign in_neg = in_value[VALUE_WIDTH-1];
  assign in_mag = in_neg ? (~in_value + VALUE_WIDTH'(1)) : in_value;

  assign in_stall = !rdy[0];

  // Stage 0: sign and magnitude
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r[0] <= 1'b0;
    end else if (rdy[0]) begin
      vld_r[0] <= in_valid;
    end
    if (rdy[0]) begin
      neg_r[0] <= in_neg;
      bin_r[0] <= PADW'(in_mag);
    end
  end

  genvar s;
  generate
    for (s = 0; s <= NSTG; s++) begin : g_rdy
      assign rdy[s] = !vld_r[s] || rdy[s+1];
    end

    for (s = 1; s <= NSTG; s++) begin : g_stage
      bcd_t bcd_in;
      bcd_t bcd_nxt;

      if (s == 1) begin : g_first
        assign bcd_in = '0;
      end else begin : g_rest
        assign bcd_in = bcd_r[s-1];
      end

      assign bcd_nxt = dabble_chunk(bcd_in, bin_r[s-1][PADW-1 -: BPS]);

      always_ff @(posedge clk) begin
        if (!rst_n) begin
          vld_r[s] <= 1'b0;
        end else if (rdy[s]) begin
          vld_r[s] <= vld_r[s-1];
        end
        if (rdy[s]) begin
          neg_r[s] <= neg_r[s-1];
          bcd_r[s] <= bcd_nxt;
        end
      end

      if (s < NSTG) begin : g_bin
        always_ff @(posedge clk) begin
          if (rdy[s]) begin
            bin_r[s] <= bin_r[s-1] << BPS;
          end
        end
      end
    end
  endgenerate

  // Most significant nonzero digit; zero keeps index 0
  always_comb begin
    top_idx = '0;
    for (int i = 0; i < NDIG; i++) begin
      if (bcd_r[NSTG][i] != '0) begin
        top_idx = IDXW'(i);
      end
    end
  end

  assign out_free = !out_valid_r || !out_stall;
  assign emit     = ser_vld_r && out_free;
  assign last_nxt = !ser_neg_r && (ser_idx_r == '0);
  assign char_nxt = ser_neg_r ? CHAR_MINUS
                              : (CHAR_ZERO + char_t'(ser_bcd_r[ser_idx_r]));
  assign ser_done = emit && last_nxt;
  assign ser_load = !ser_vld_r || ser_done;
  assign rdy[NSTG+1] = ser_load;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ser_vld_r <= 1'b0;
      ser_neg_r <= 1'b0;
      ser_idx_r <= '0;
    end else if (ser_load) begin
      ser_vld_r <= vld_r[NSTG];
      ser_neg_r <= vld_r[NSTG] && neg_r[NSTG];
      ser_idx_r <= top_idx;
    end else if (emit) begin
      if (ser_neg_r) begin
        ser_neg_r <= 1'b0;
      end else begin
        ser_idx_r <= ser_idx_r - IDXW'(1);
      end
    end
    if (ser_load) begin
      ser_bcd_r <= bcd_r[NSTG];
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= ser_vld_r;
    end
    if (out_free) begin
      out_char_r <= char_nxt;
      out_last_r <= last_nxt;
    end
  end

  assign out_valid     = out_valid_r;
  assign out_char_code = out_char_r;
  assign out_last_char = out_last_r;

`ifndef NO_ASSERTIONS
  a_minus_not_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_char_code == CHAR_MINUS) |-> !out_last_char)
    else $error("minus sign flagged as last character");

  a_char_range: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_char_code == CHAR_MINUS) ||
                  ((out_char_code >= CHAR_ZERO) && (out_char_code <= CHAR_ZERO + char_t'(9))))
    else $error("character outside sign and digit codes");

  a_sign_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    ser_neg_r |-> ser_vld_r)
    else $error("pending sign without an item in the serializer");

  a_idx_range: assert property (@(posedge clk) disable iff (!rst_n)
    ser_vld_r |-> ser_idx_r <= IDXW'(NDIG - 1))
    else $error("serializer digit index out of range");

  a_accept_enters: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && !in_stall |=> vld_r[0])
    else $error("accepted request did not enter the pipeline");
`endif

endmodule
